// ----- hdl/sle_pkg.sv -----
`timescale 1ns / 1ps

package sle_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int VALUE_BITS_DEF = 32;
    localparam int CMD_W          = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT    = 3'd0,
        CMD_REMOVE    = 3'd1,
        CMD_POP_FRONT = 3'd2,
        CMD_POP_BACK  = 3'd3,
        CMD_CLEAR     = 3'd4
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic capture;
        logic do_insert;
        logic do_remove;
        logic do_pop_front;
    } cell_ctl_t;

endpackage

// ----- hdl/sle_cell.sv -----
`timescale 1ns / 1ps

module sle_cell #(
    parameter int VALUE_BITS = sle_pkg::VALUE_BITS_DEF,
    parameter int CNT_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sle_pkg::cell_ctl_t           ctl,
    input  logic [CNT_W-1:0]             count,
    input  logic signed [VALUE_BITS-1:0] probe_value,
    input  logic signed [VALUE_BITS-1:0] insert_value,
    input  logic signed [VALUE_BITS-1:0] left_entry,
    input  logic                         left_ge,
    input  logic signed [VALUE_BITS-1:0] right_entry,
    output logic signed [VALUE_BITS-1:0] entry,
    output logic                         ge,
    output logic                         hit,
    output logic [VALUE_BITS-1:0]        back_value
);

    logic signed [VALUE_BITS-1:0] entry_reg;
    logic signed [VALUE_BITS-1:0] entry_next;
    logic                         ge_reg;
    logic                         ge_next;
    logic                         eq_reg;
    logic                         eq_next;
    logic                         occupied;
    logic                         tail_slot;
    logic                         last_slot;

    assign occupied  = CNT_W'(INDEX) < count;
    assign tail_slot = CNT_W'(INDEX) == count;
    assign last_slot = CNT_W'(INDEX + 1) == count;

    // Each cell compares its own entry against the requested value in parallel.
    always_comb
    begin
        ge_next = ge_reg;
        eq_next = eq_reg;
        if (ctl.capture)
        begin
            ge_next = occupied && (entry_reg >= probe_value);
            eq_next = entry_reg == probe_value;
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.do_insert)
        begin
            if (left_ge)
            begin
                entry_next = left_entry;
            end
            else if (ge_reg || tail_slot)
            begin
                entry_next = insert_value;
            end
        end
        else if (ctl.do_remove)
        begin
            if (ge_reg)
            begin
                entry_next = right_entry;
            end
        end
        else if (ctl.do_pop_front)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            ge_reg <= ge_next;
            eq_reg <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry      = entry_reg;
    assign ge         = ge_reg;
    assign hit        = ge_reg && !left_ge && eq_reg;
    assign back_value = last_slot ? entry_reg : '0;

endmodule

// ----- hdl/sle_ctrl.sv -----
`timescale 1ns / 1ps

module sle_ctrl #(
    parameter int DEPTH      = sle_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = sle_pkg::VALUE_BITS_DEF,
    parameter int CNT_W      = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  sle_pkg::cmd_t                cmd_in,
    input  logic signed [VALUE_BITS-1:0] value_in,
    input  logic                         found,
    input  logic signed [VALUE_BITS-1:0] front_value,
    input  logic signed [VALUE_BITS-1:0] back_value,
    output sle_pkg::cell_ctl_t           ctl,
    output logic [CNT_W-1:0]             count,
    output logic signed [VALUE_BITS-1:0] value_hold,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_ok,
    output logic signed [VALUE_BITS-1:0] out_popped,
    output logic [CNT_W-1:0]             out_count
);

    sle_pkg::state_t              state_reg;
    sle_pkg::state_t              state_next;
    sle_pkg::cmd_t                cmd_reg;
    logic signed [VALUE_BITS-1:0] value_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         valid_reg;
    logic                         valid_next;
    logic                         ok_reg;
    logic signed [VALUE_BITS-1:0] popped_reg;
    logic [CNT_W-1:0]             ocount_reg;
    logic                         ok_res;
    logic signed [VALUE_BITS-1:0] popped_res;
    logic                         accept;
    logic                         fire;
    logic                         full;
    logic                         empty;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sle_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sle_pkg::ST_APPLY;
                end
            end
            sle_pkg::ST_APPLY:
            begin
                if (!valid_reg || out_ready)
                begin
                    state_next = sle_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sle_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = state_reg == sle_pkg::ST_IDLE;
        accept   = in_ready && in_valid;
        fire     = (state_reg == sle_pkg::ST_APPLY) && (!valid_reg || out_ready);
        ctl.capture      = accept;
        ctl.do_insert    = fire && (cmd_reg == sle_pkg::CMD_INSERT) && !full;
        ctl.do_remove    = fire && (cmd_reg == sle_pkg::CMD_REMOVE) && found;
        ctl.do_pop_front = fire && (cmd_reg == sle_pkg::CMD_POP_FRONT) && !empty;
    end

    always_comb
    begin
        ok_res     = 1'b0;
        popped_res = '0;
        count_next = count_reg;
        case (cmd_reg)
            sle_pkg::CMD_INSERT:
            begin
                if (!full)
                begin
                    ok_res     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            sle_pkg::CMD_REMOVE:
            begin
                if (found)
                begin
                    ok_res     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            sle_pkg::CMD_POP_FRONT:
            begin
                if (!empty)
                begin
                    ok_res     = 1'b1;
                    popped_res = front_value;
                    count_next = count_reg - 1'b1;
                end
            end
            sle_pkg::CMD_POP_BACK:
            begin
                if (!empty)
                begin
                    ok_res     = 1'b1;
                    popped_res = back_value;
                    count_next = count_reg - 1'b1;
                end
            end
            sle_pkg::CMD_CLEAR:
            begin
                ok_res     = 1'b1;
                count_next = '0;
            end
            default:
            begin
                ok_res = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sle_pkg::ST_IDLE;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd_in;
            value_reg <= value_in;
        end
        if (fire)
        begin
            ok_reg     <= ok_res;
            popped_reg <= popped_res;
            ocount_reg <= count_next;
        end
    end

    assign count      = count_reg;
    assign value_hold = value_reg;
    assign out_valid  = valid_reg;
    assign out_ok     = ok_reg;
    assign out_popped = popped_reg;
    assign out_count  = ocount_reg;

endmodule

// ----- hdl/sorted_list_engine.sv -----
`timescale 1ns / 1ps

// Sorted list engine: keeps up to DEPTH signed values in ascending order.
// Each request on the s_ channel carries a command and a value; the engine
// answers every request with exactly one result on the m_ channel.
// Commands: insert in order, remove the first equal value, pop the smallest,
// pop the largest, and clear. A result carries a success flag, the popped
// value (zero unless a pop succeeded) and the entry count after the request.
// The list lives in a row of cells, one entry per cell. In the cycle a
// request is accepted every cell compares its entry with the value; in the
// update state each cell loads from its left or right neighbor or new value.
// The result register loads together with the cells and drives m_tvalid.
// No new request is taken until the update is done; s_tready drops in the
// update state. A result waiting in the output register does not block the
// next acceptance, but the update of that next request waits until the
// result has been taken, so a stalled receiver stalls the list.
// Reset empties the list and drops m_tvalid; stored values are not cleared.
module sorted_list_engine #(
    parameter int DEPTH      = sle_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = sle_pkg::VALUE_BITS_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int IN_W      = ((sle_pkg::CMD_W + VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((1 + VALUE_BITS + CNT_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,  // cmd, value
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata   // ok, popped, count
);

    sle_pkg::cell_ctl_t           ctl;
    logic [CNT_W-1:0]             count;
    logic signed [VALUE_BITS-1:0] probe_value;
    logic signed [VALUE_BITS-1:0] value_hold;
    logic signed [VALUE_BITS-1:0] entry_ext [0:DEPTH+1];
    logic                         ge_ext [0:DEPTH];
    logic [DEPTH-1:0]             hit;
    logic [VALUE_BITS-1:0]        back_sel [0:DEPTH-1];
    logic [VALUE_BITS-1:0]        back_value;
    logic                         found;
    logic                         out_ok;
    logic signed [VALUE_BITS-1:0] out_popped;
    logic [CNT_W-1:0]             out_count;

    assign probe_value      = s_tdata[sle_pkg::CMD_W +: VALUE_BITS];
    assign entry_ext[0]     = '0;
    assign entry_ext[DEPTH+1] = '0;
    assign ge_ext[0]        = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            sle_cell #(
                .VALUE_BITS (VALUE_BITS),
                .CNT_W      (CNT_W),
                .INDEX      (gi)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (ctl),
                .count        (count),
                .probe_value  (probe_value),
                .insert_value (value_hold),
                .left_entry   (entry_ext[gi]),
                .left_ge      (ge_ext[gi]),
                .right_entry  (entry_ext[gi+2]),
                .entry        (entry_ext[gi+1]),
                .ge           (ge_ext[gi+1]),
                .hit          (hit[gi]),
                .back_value   (back_sel[gi])
            );
        end
    endgenerate

    assign found = |hit;

    always_comb
    begin
        back_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_value = back_value | back_sel[i];
        end
    end

    sle_ctrl #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .cmd_in      (sle_pkg::cmd_t'(s_tdata[sle_pkg::CMD_W-1:0])),
        .value_in    (probe_value),
        .found       (found),
        .front_value (entry_ext[1]),
        .back_value  (back_value),
        .ctl         (ctl),
        .count       (count),
        .value_hold  (value_hold),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_ok      (out_ok),
        .out_popped  (out_popped),
        .out_count   (out_count)
    );

    assign m_tdata = OUT_W'({out_count, out_popped, out_ok});

endmodule

// ----- tb/sv/sorted_list_engine_tb.sv -----
`timescale 1ns / 1ps

module sorted_list_engine_tb;

    localparam int DEPTH      = sle_pkg::DEPTH_DEF;
    localparam int VB         = sle_pkg::VALUE_BITS_DEF;
    localparam int CMD_W      = sle_pkg::CMD_W;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IN_W       = ((CMD_W + VB + 7) / 8) * 8;
    localparam int OUT_W      = ((1 + VB + CNT_W + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 5000;
    localparam int MAX_GAP    = 24;
    localparam int PHASE_ITEMS = 112;

    typedef struct {
        logic                 ok;
        logic signed [VB-1:0] popped;
        logic [CNT_W-1:0]     count;
    } list_result_t;

    class list_scoreboard;
        logic signed [VB-1:0] slots [DEPTH];
        int                   fill;
        list_result_t         expected_q [$];
        int                   errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        function void note_request(logic [IN_W-1:0] d);
            logic [CMD_W-1:0]     cmd;
            logic signed [VB-1:0] v;
            list_result_t         res;
            int                   pos;
            cmd        = d[CMD_W-1:0];
            v          = d[CMD_W+VB-1:CMD_W];
            res.ok     = 1'b0;
            res.popped = '0;
            case (sle_pkg::cmd_t'(cmd))
                sle_pkg::CMD_INSERT:
                begin
                    if (fill < DEPTH)
                    begin
                        pos = fill;
                        for (int i = 0; i < fill; i++)
                        begin
                            if (slots[i] >= v)
                            begin
                                pos = i;
                                break;
                            end
                        end
                        for (int j = fill; j > pos; j--)
                            slots[j] = slots[j-1];
                        slots[pos] = v;
                        fill++;
                        res.ok = 1'b1;
                    end
                end
                sle_pkg::CMD_REMOVE:
                begin
                    pos = -1;
                    for (int i = 0; i < fill; i++)
                    begin
                        if (slots[i] == v)
                        begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos >= 0)
                    begin
                        for (int j = pos; j + 1 < fill; j++)
                            slots[j] = slots[j+1];
                        fill--;
                        res.ok = 1'b1;
                    end
                end
                sle_pkg::CMD_POP_FRONT:
                begin
                    if (fill > 0)
                    begin
                        res.popped = slots[0];
                        for (int j = 0; j + 1 < fill; j++)
                            slots[j] = slots[j+1];
                        fill--;
                        res.ok = 1'b1;
                    end
                end
                sle_pkg::CMD_POP_BACK:
                begin
                    if (fill > 0)
                    begin
                        res.popped = slots[fill-1];
                        fill--;
                        res.ok = 1'b1;
                    end
                end
                sle_pkg::CMD_CLEAR:
                begin
                    fill   = 0;
                    res.ok = 1'b1;
                end
                default: ;
            endcase
            res.count = CNT_W'(fill);
            expected_q.push_back(res);
        endfunction

        task check_result(logic [OUT_W-1:0] d);
            list_result_t         want;
            logic                 got_ok;
            logic signed [VB-1:0] got_popped;
            logic [CNT_W-1:0]     got_count;
            got_ok     = d[0];
            got_popped = d[VB:1];
            got_count  = d[VB+CNT_W:VB+1];
            if (expected_q.size() == 0)
            begin
                report("unexpected result, count", got_count, 0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got_ok !== want.ok)
                    report("ok", got_ok, want.ok);
                if (got_popped !== want.popped)
                    report("popped", got_popped, want.popped);
                if (got_count !== want.count)
                    report("count", got_count, want.count);
            end
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    list_scoreboard       sb;
    int                   idle_pct;
    int                   stall_pct;
    int                   quiet_cycles;
    logic signed [VB-1:0] value_pool [8];

    sorted_list_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic signed [VB-1:0] v);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W-CMD_W-VB){1'b0}}, v, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [CMD_W-1:0] pick_cmd(int mode);
        int r;
        r = $urandom_range(99);
        if (r >= 97)
            return CMD_W'($urandom_range(7, 5));
        case (mode)
            0:
            begin
                if (r < 75) return sle_pkg::CMD_INSERT;
                if (r < 85) return sle_pkg::CMD_REMOVE;
                if (r < 90) return sle_pkg::CMD_POP_FRONT;
                if (r < 95) return sle_pkg::CMD_POP_BACK;
            end
            1:
            begin
                if (r < 20) return sle_pkg::CMD_INSERT;
                if (r < 50) return sle_pkg::CMD_REMOVE;
                if (r < 70) return sle_pkg::CMD_POP_FRONT;
                if (r < 94) return sle_pkg::CMD_POP_BACK;
            end
            default:
            begin
                if (r < 40) return sle_pkg::CMD_INSERT;
                if (r < 65) return sle_pkg::CMD_REMOVE;
                if (r < 80) return sle_pkg::CMD_POP_FRONT;
                if (r < 94) return sle_pkg::CMD_POP_BACK;
            end
        endcase
        return sle_pkg::CMD_CLEAR;
    endfunction

    function automatic logic signed [VB-1:0] pick_value();
        if ($urandom_range(3) == 0)
            return VB'($urandom);
        return value_pool[$urandom_range(7)];
    endfunction

    task automatic refresh_pool();
        value_pool[0] = {1'b1, {(VB-1){1'b0}}};
        value_pool[1] = {1'b0, {(VB-1){1'b1}}};
        value_pool[2] = '0;
        value_pool[3] = '1;
        value_pool[4] = VB'($urandom);
        value_pool[5] = VB'($urandom);
        value_pool[6] = VB'($signed(VB'($urandom_range(20))) - 10);
        value_pool[7] = VB'($signed(VB'($urandom_range(20))) - 10);
    endtask

    initial
    begin
        sb           = new();
        quiet_cycles = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(sle_pkg::CMD_INSERT, {1'b0, {(VB-1){1'b1}}});
        send_request(sle_pkg::CMD_INSERT, {1'b1, {(VB-1){1'b0}}});
        send_request(sle_pkg::CMD_INSERT, 0);
        send_request(sle_pkg::CMD_INSERT, 0);
        send_request(sle_pkg::CMD_REMOVE, 0);
        send_request(sle_pkg::CMD_REMOVE, 7);
        send_request(sle_pkg::CMD_POP_FRONT, 0);
        send_request(sle_pkg::CMD_POP_BACK, '1);
        send_request(CMD_W'(5), 1);
        send_request(CMD_W'(6), '1);
        send_request(CMD_W'(7), 0);
        send_request(sle_pkg::CMD_INSERT, -5);
        send_request(sle_pkg::CMD_CLEAR, '1);
        send_request(sle_pkg::CMD_POP_FRONT, 0);
        send_request(sle_pkg::CMD_POP_BACK, 0);
        send_request(sle_pkg::CMD_REMOVE, 0);
        send_request(sle_pkg::CMD_CLEAR, 0);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 68;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 68;
                end
                default:
                begin
                    idle_pct  = 6;
                    stall_pct = 6;
                end
            endcase
            refresh_pool();
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(pick_cmd((n / 38) % 3), pick_value());
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report("results left over", sb.expected_q.size(), 0);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
